// ===== sv/pru_pkg.sv =====
// Shared types and constants for the PNG row unfilter.
// No dependencies; every other file in this folder imports this package.
package pru_pkg;

  // Line store geometry and field widths.
  localparam int MAX_COLUMNS = 4096;
  localparam int ADDR_W      = $clog2(MAX_COLUMNS);
  localparam int COL_W       = 13;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PNG_MODE = 1'd1;

  // PNG filter type codes handled here.
  localparam logic [BYTE_W-1:0] FILT_NONE = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB  = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP   = 8'd2;

  // What an accepted byte is, as decided at acceptance.
  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_FILTER = 2'd1,
    KIND_DATA   = 2'd2
  } kind_t;

  // Tag that travels with a byte from the position tracker to reconstruction.
  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] idx;
    logic              last;
  } tag_t;

endpackage

// ===== sv/pru_line_store.sv =====
// Line store holding the previous reconstructed row.
// One write port and one registered read port; depends on pru_pkg.
module pru_line_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [pru_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [pru_pkg::BYTE_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [pru_pkg::ADDR_W-1:0]   rd_addr,
  output logic [pru_pkg::BYTE_W-1:0]   rd_data
);
  import pru_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_COLUMNS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/pru_ctrl.sv =====
// Configuration registers and row position tracking at byte acceptance.
// Produces the tag and line store read address per byte; depends on pru_pkg.
module pru_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pru_pkg::COL_W-1:0]     cfg_wdata,
  input  logic                          in_fire,
  output pru_pkg::tag_t                 tag
);
  import pru_pkg::*;

  logic [COL_W-1:0] columns_r;
  logic             png_mode_r;
  logic [COL_W-1:0] pos_r, pos_nxt;
  logic [COL_W-1:0] row_len;
  logic [COL_W-1:0] pos_m1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r  <= COL_W'(1);
      png_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COLUMNS:  columns_r  <= cfg_wdata;
        CFG_PNG_MODE: png_mode_r <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // Effective row length: zero means one, larger than the store saturates.
  always_comb begin
    if (columns_r == '0) begin
      row_len = COL_W'(1);
    end else if (columns_r > COL_W'(MAX_COLUMNS)) begin
      row_len = COL_W'(MAX_COLUMNS);
    end else begin
      row_len = columns_r;
    end
  end

  // Classify the byte at the input and work out the next position.
  always_comb begin
    pos_m1   = pos_r - COL_W'(1);
    tag.idx  = pos_m1[ADDR_W-1:0];
    tag.last = 1'b0;
    pos_nxt  = pos_r;
    if (!png_mode_r) begin
      tag.kind = KIND_PASS;
    end else if (pos_r == '0) begin
      tag.kind = KIND_FILTER;
      pos_nxt  = COL_W'(1);
    end else begin
      tag.kind = KIND_DATA;
      tag.last = (pos_r >= row_len);
      pos_nxt  = tag.last ? '0 : pos_r + COL_W'(1);
    end
  end

  // Position counter; zero means the filter-type byte comes next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
    end
  end

  // The position never runs past the line store.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= COL_W'(MAX_COLUMNS))
    else $error("row position beyond line store");

  // The last data byte of a row sends the tracker back to the filter byte.
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && tag.kind == KIND_DATA && tag.last |=> pos_r == '0)
    else $error("row did not wrap after last byte");

endmodule

// ===== sv/pru_recon.sv =====
// Reconstruction stage and result register with the valid/stall handshake.
// Applies None, Sub and Up, updates row state and writes the line store; uses pru_pkg.
module pru_recon (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pru_pkg::BYTE_W-1:0]  in_byte,
  input  pru_pkg::tag_t               in_tag,
  input  logic [pru_pkg::BYTE_W-1:0]  prior_byte,
  output logic                        wr_en,
  output logic [pru_pkg::ADDR_W-1:0]  wr_addr,
  output logic [pru_pkg::BYTE_W-1:0]  wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pru_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_row_last,
  output logic                        out_bad_filter
);
  import pru_pkg::*;

  logic              s1_v_r;
  logic [BYTE_W-1:0] s1_byte_r;
  tag_t              s1_tag_r;
  logic [BYTE_W-1:0] row_filter_r;
  logic [BYTE_W-1:0] left_r;
  logic              first_row_r;
  logic              out_v_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_bad_r;

  logic              in_fire;
  logic              s1_emit;
  logic              s1_go;
  logic              out_free;
  logic [BYTE_W-1:0] recon;
  logic              bad;

  // Handshake: the stage moves on when its result has room or it makes none.
  assign out_free = !out_v_r || !out_stall;
  assign s1_emit  = (s1_tag_r.kind != KIND_FILTER);
  assign s1_go    = s1_v_r && (!s1_emit || out_free);
  assign in_stall = s1_v_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  // Input register; the line store read was issued at the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
      s1_tag_r  <= in_tag;
    end
  end

  // Undo the row filter, modulo 256.
  always_comb begin
    bad = 1'b0;
    case (row_filter_r)
      FILT_NONE: recon = s1_byte_r;
      FILT_SUB:  recon = s1_byte_r + left_r;
      FILT_UP:   recon = first_row_r ? s1_byte_r : s1_byte_r + prior_byte;
      default: begin
        recon = s1_byte_r;
        bad   = 1'b1;
      end
    endcase
  end

  // Store the reconstructed data byte for the next row.
  assign wr_en   = s1_go && (s1_tag_r.kind == KIND_DATA);
  assign wr_addr = s1_tag_r.idx;
  assign wr_data = recon;

  // Row state: filter type, left neighbor and first-row flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_filter_r <= FILT_NONE;
      left_r       <= '0;
      first_row_r  <= 1'b1;
    end else if (s1_go) begin
      case (s1_tag_r.kind)
        KIND_FILTER: begin
          row_filter_r <= s1_byte_r;
          left_r       <= '0;
        end
        KIND_DATA: begin
          left_r <= recon;
          if (s1_tag_r.last) begin
            first_row_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      if (s1_tag_r.kind == KIND_DATA) begin
        out_byte_r <= recon;
        out_last_r <= s1_tag_r.last;
        out_bad_r  <= bad;
      end else begin
        out_byte_r <= s1_byte_r;
        out_last_r <= 1'b0;
        out_bad_r  <= 1'b0;
      end
    end
  end

  assign out_valid      = out_v_r;
  assign out_byte       = out_byte_r;
  assign out_row_last   = out_last_r;
  assign out_bad_filter = out_bad_r;

  // A byte held in the stage keeps its contents until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_go |=> s1_v_r && $stable(s1_byte_r) && $stable(s1_tag_r))
    else $error("stage contents changed while held");

  // A filter-type byte starts the row with a zero left neighbor.
  a_left_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_tag_r.kind == KIND_FILTER |=> left_r == '0)
    else $error("left byte not cleared at row start");

  // A filter-type byte never produces a result.
  a_filter_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_tag_r.kind == KIND_FILTER && !out_v_r |=> !out_v_r)
    else $error("filter byte produced a result");

endmodule

// ===== sv/png_row_unfilter.sv =====
// Top level of the PNG row unfilter: position tracking, line store, reconstruction.
// Instantiates pru_ctrl, pru_line_store and pru_recon; depends on pru_pkg.
//
//   Channel | Ports                                        | Direction
//   --------+----------------------------------------------+----------
//   input   | in_valid, in_stall, in_byte                  | in
//   result  | out_valid, out_stall, out_byte,              | out
//           | out_row_last, out_bad_filter                 |
//   config  | cfg_wr_en, cfg_index, cfg_wdata              | in
//
// One byte is accepted per cycle while in_stall is low; a byte's result is loaded from the
// input register into the result register, and out_valid rises with that load.
// The line store read is issued at acceptance, so its data arrives with the input register.
// A filter-type byte gives no result.
// Reset is synchronous and active low; the line store is not cleared.
// A stalled result holds the pipeline; in_stall follows out_stall if both stages hold non-filter bytes.
module png_row_unfilter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pru_pkg::COL_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pru_pkg::BYTE_W-1:0]    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pru_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_row_last,
  output logic                          out_bad_filter
);
  import pru_pkg::*;

  tag_t              tag;
  logic              in_fire;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] prior_byte;

  assign in_fire = in_valid && !in_stall;

  // Row position tracking and configuration.
  pru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .tag       (tag)
  );

  // Previous row; read as the byte is accepted, written when it is reconstructed.
  pru_line_store u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (tag.idx),
    .rd_data (prior_byte)
  );

  // Reconstruction and result register.
  pru_recon u_recon (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_tag         (tag),
    .prior_byte     (prior_byte),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_row_last   (out_row_last),
    .out_bad_filter (out_bad_filter)
  );

endmodule

// ===== dv/png_row_unfilter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for png_row_unfilter: a directed table, then random phases
// of rows under changing settings. Depends on pru_pkg and the png_row_unfilter RTL.
module png_row_unfilter_tb;
  import pru_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 1650;
  localparam int MIN_PHASES     = 10;

  // One reconstructed byte as seen on the result channel.
  typedef struct packed {
    logic [BYTE_W-1:0] val;
    logic              last;
    logic              bad;
  } pixel_t;

  // One byte waiting to be sent, with a hand-written answer where the table gives one.
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              typed;
    pixel_t            want;
  } stim_t;

  typedef enum logic {STEP_BYTE, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [COL_W-1:0]     val;
    logic                 typed;
    pixel_t               want;
  } dir_step_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COLUMNS;
  logic [COL_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_row_last;
  logic                 out_bad_filter;

  png_row_unfilter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_row_last  (out_row_last),
    .out_bad_filter(out_bad_filter)
  );

  always #1 clk = ~clk;

  // Register values as last written; shared by the predictor and the row generator.
  logic [COL_W-1:0] cur_columns = 13'd1;
  logic             cur_png     = 1'b0;

  // Predictor state.
  logic [BYTE_W-1:0] prior_line [MAX_COLUMNS];
  int unsigned       col_pos      = 0;
  logic [BYTE_W-1:0] row_filt     = '0;
  logic [BYTE_W-1:0] left_val     = '0;
  logic              on_first_row = 1'b1;

  // The generator's own view of where the stream stands, so it can shape rows.
  int unsigned       gen_pos     = 0;
  logic [BYTE_W-1:0] gen_filt    = '0;
  logic              gen_first   = 1'b1;
  int unsigned       gen_written = 0;

  stim_t       byte_q[$];
  pixel_t      expected_q[$];
  int unsigned err_cnt     = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left   = 0;
  int unsigned seg_left    = 0;
  int unsigned stall_pct   = 0;
  logic        long_hold   = 1'b0;
  logic        hold_done   = 1'b0;

  // Hand-checked opening sequence: pass-through, first-row Up, Sub wrap, Up on a
  // later row, unknown filter types, a mode change mid-row and columns set to zero.
  dir_step_t dir_tab [27] = '{
    '{STEP_BYTE, CFG_COLUMNS,  13'h000,          1'b1, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h0FF,          1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{STEP_CFG,  CFG_PNG_MODE, 13'd1,            1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  {5'd0, FILT_UP},   1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h0A5,          1'b1, '{8'hA5, 1'b1, 1'b0}},
    '{STEP_CFG,  CFG_COLUMNS,  13'd3,            1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  {5'd0, FILT_SUB},  1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h080,          1'b1, '{8'h80, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h090,          1'b1, '{8'h10, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h0FF,          1'b1, '{8'h0F, 1'b1, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  {5'd0, FILT_UP},   1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h0FF,          1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h001,          1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h000,          1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h007,          1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h05A,          1'b1, '{8'h5A, 1'b0, 1'b1}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h000,          1'b1, '{8'h00, 1'b0, 1'b1}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h0FF,          1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{STEP_BYTE, CFG_COLUMNS,  {5'd0, FILT_NONE}, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h033,          1'b1, '{8'h33, 1'b0, 1'b0}},
    '{STEP_CFG,  CFG_PNG_MODE, 13'd0,            1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h0C3,          1'b1, '{8'hC3, 1'b0, 1'b0}},
    '{STEP_CFG,  CFG_PNG_MODE, 13'd1,            1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_CFG,  CFG_COLUMNS,  13'd0,            1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h044,          1'b1, '{8'h44, 1'b1, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h0FF,          1'b0, '{8'h00, 1'b0, 1'b0}},
    '{STEP_BYTE, CFG_COLUMNS,  13'h012,          1'b1, '{8'h12, 1'b1, 1'b1}}
  };

  // Row length as the block sees it: zero counts as one, large values saturate.
  function automatic int unsigned row_len(input logic [COL_W-1:0] cols);
    if (cols == '0) return 1;
    if (cols > MAX_COLUMNS) return MAX_COLUMNS;
    return 32'(cols);
  endfunction

  // Predicts the result of one accepted byte; returns 0 for a filter-type byte.
  function automatic logic unfilter_byte(input logic [BYTE_W-1:0] b, output pixel_t px);
    int unsigned slot;
    px = '0;
    if (!cur_png) begin
      px.val = b;
      return 1'b1;
    end
    if (col_pos == 0) begin
      row_filt = b;
      left_val = '0;
      col_pos  = 1;
      return 1'b0;
    end
    slot = (col_pos > MAX_COLUMNS) ? MAX_COLUMNS - 1 : col_pos - 1;
    case (row_filt)
      FILT_NONE: px.val = b;
      FILT_SUB:  px.val = b + left_val;
      FILT_UP:   px.val = on_first_row ? b : b + prior_line[slot[ADDR_W-1:0]];
      default: begin
        px.val = b;
        px.bad = 1'b1;
      end
    endcase
    prior_line[slot[ADDR_W-1:0]] = px.val;
    left_val                     = px.val;
    px.last                      = (col_pos >= row_len(cur_columns));
    if (px.last) begin
      col_pos      = 0;
      on_first_row = 1'b0;
    end else begin
      col_pos++;
    end
    return 1'b1;
  endfunction

  // Follows the row structure of the bytes queued so far.
  function automatic void track_byte(input logic [BYTE_W-1:0] b);
    if (!cur_png) return;
    if (gen_pos == 0) begin
      gen_filt = b;
      gen_pos  = 1;
      return;
    end
    if (gen_pos > gen_written) gen_written = gen_pos;
    if (gen_pos >= row_len(cur_columns)) begin
      gen_pos   = 0;
      gen_first = 1'b0;
    end else begin
      gen_pos++;
    end
  endfunction

  // Picks the next stream byte: a filter type at the head of a row, else random data.
  function automatic logic [BYTE_W-1:0] next_byte();
    logic [BYTE_W-1:0] b;
    int unsigned       pick;
    b = BYTE_W'($urandom);
    if (cur_png && gen_pos == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) b = FILT_NONE;
      else if (pick < 60) b = FILT_SUB;
      else if (pick < 90) b = FILT_UP;
      else b = BYTE_W'($urandom_range(3, 255));
      // Up may only read line store entries that an earlier row has filled.
      if (b == FILT_UP && !gen_first && row_len(cur_columns) > gen_written) b = FILT_SUB;
    end
    track_byte(b);
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    err_cnt++;
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Returns once every queued byte is taken and every result has come back.
  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    if (idx == CFG_COLUMNS) cur_columns = val;
    else cur_png = val[0];
  endtask

  // Both channels: prediction on input transactions, checking on result
  // transactions, the sender's bursts and gaps, and the watchdog.
  always @(posedge clk) begin : handshakes
    stim_t  head;
    pixel_t px;
    pixel_t want;
    logic   produced;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        head     = byte_q.pop_front();
        produced = unfilter_byte(head.b, px);
        if (head.typed) expected_q.push_back(head.want);
        else if (produced) expected_q.push_back(px);
      end

      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_byte, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_byte !== want.val) report_mismatch("out_byte", out_byte, want.val);
          if (out_row_last !== want.last)
            report_mismatch("out_row_last", BYTE_W'(out_row_last), BYTE_W'(want.last));
          if (out_bad_filter !== want.bad)
            report_mismatch("out_bad_filter", BYTE_W'(out_bad_filter), BYTE_W'(want.bad));
        end
      end

      // A held byte stays put; otherwise offer the next one unless in a gap.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid <= 1'b1;
          in_byte  <= byte_q[0].b;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("png_row_unfilter_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // Receiver: stall segments of varying density, plus one long hold-off.
  always @(posedge clk) begin : receiver
    if (rst_n) begin
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 80);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    stim_t            item;
    int unsigned      sent;
    int unsigned      n;
    int unsigned      len;
    int unsigned      phase;
    logic [COL_W-1:0] cols;
    logic [COL_W-1:0] mode_word;
    logic             png;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; settings change only once the block has gone quiet.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STEP_CFG) begin
        wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].val);
      end else begin
        track_byte(dir_tab[i].val[BYTE_W-1:0]);
        byte_q.push_back('{dir_tab[i].val[BYTE_W-1:0], dir_tab[i].typed, dir_tab[i].want});
      end
    end
    wait_idle();

    // Random phases. Phase 3 carries the long receiver hold-off, phase 5 ends on a
    // row boundary, phase 6 writes a row length above the line store size, and
    // phase 9 writes the largest legal row length.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BYTES || phase < MIN_PHASES) begin
      png = ($urandom_range(0, 99) < 85);
      if (phase == 6) begin
        cols = '1;
        png  = 1'b1;
      end else if (phase == 9) begin
        cols = 13'd4096;
        png  = 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0:                                 cols = '0;
          1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: cols = COL_W'($urandom_range(1, 8));
          12, 13, 14, 15, 16:                cols = COL_W'($urandom_range(9, 64));
          default:                           cols = COL_W'($urandom_range(65, 300));
        endcase
      end
      if (phase == 5) png = 1'b1;
      // A row in Up mode must not grow past what the line store holds.
      if (gen_pos != 0 && gen_filt == FILT_UP && !gen_first && row_len(cols) > gen_written)
        cols = COL_W'(gen_written);
      mode_word    = COL_W'($urandom_range(0, 8191));
      mode_word[0] = png;
      write_reg(CFG_COLUMNS, cols);
      write_reg(CFG_PNG_MODE, mode_word);

      len = row_len(cols);
      if (!png) n = $urandom_range(5, 40);
      else n = (len + 1) * $urandom_range(1, 5) + $urandom_range(0, len);
      if (n > 600) n = 600;
      if (phase == 3) begin
        if (n < 200) n = 200;
        long_hold = 1'b1;
      end

      item.typed = 1'b0;
      item.want  = '0;
      repeat (n) begin
        item.b = next_byte();
        byte_q.push_back(item);
      end
      if (phase == 5) begin
        while (gen_pos != 0) begin
          item.b = next_byte();
          byte_q.push_back(item);
        end
      end
      sent += n;
      phase++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("png_row_unfilter_tb OK");
    end else begin
      $display("png_row_unfilter_tb NOT OK");
    end
    $finish;
  end

endmodule
